FILE: hw/rtl/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk, suspended while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/gsbc_pkg.sv
package gsbc_pkg;

  localparam int SAMPLE_W           = 16;
  localparam int RATE_W             = 17;
  localparam int PROD_W             = 2 * SAMPLE_W;
  localparam int TOTAL_W            = 32;
  localparam int WLEN_W             = 10;
  localparam int THR_W              = 20;
  localparam int CFG_IDX_W          = 1;
  localparam int CFG_DATA_W         = 20;
  localparam int COUNT_BITS_DEFAULT = 10;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 10'd500;
  localparam logic [THR_W-1:0]  THR_RESET  = 20'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH   = 1'b0,
    REG_STILL_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_LOAD,
    S_SQ_RUN,
    S_DIVSQ_LOAD,
    S_DIVSQ_RUN,
    S_JUDGE,
    S_DIVSUM_LOAD,
    S_DIVSUM_RUN,
    S_EMIT
  } state_t;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: hw/rtl/gsbc_ifs.sv
interface gsbc_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [gsbc_pkg::SAMPLE_W-1:0] raw_x;
  logic signed [gsbc_pkg::SAMPLE_W-1:0] raw_y;
  logic signed [gsbc_pkg::SAMPLE_W-1:0] raw_z;

  modport source (output valid, raw_x, raw_y, raw_z, input ready);
  modport sink (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

interface gsbc_rate_if;
  logic                              valid;
  logic                              ready;
  logic signed [gsbc_pkg::RATE_W-1:0] rate_x;
  logic signed [gsbc_pkg::RATE_W-1:0] rate_y;
  logic signed [gsbc_pkg::RATE_W-1:0] rate_z;
  logic                              window_closed;
  logic                              bias_updated;

  modport source (output valid, rate_x, rate_y, rate_z, window_closed, bias_updated,
                  input ready);
  modport sink (input valid, rate_x, rate_y, rate_z, window_closed, bias_updated,
                output ready);
endinterface

interface gsbc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gsbc_pkg::CFG_IDX_W-1:0]  index;
  logic [gsbc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/gsbc_sq_mul.sv
// Shift-and-add squarer, one multiplier bit per cycle.
module gsbc_sq_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [gsbc_pkg::SAMPLE_W-1:0]    mag,
  output logic [gsbc_pkg::PROD_W-1:0]      product,
  output gsbc_pkg::unit_stat_t             stat
);

  localparam int W     = gsbc_pkg::SAMPLE_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [W-1:0]     a;
  logic [W-1:0]     hi;
  logic [W-1:0]     lo;
  logic [W:0]       sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, a} : {(W + 1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a  <= mag;
      hi <= '0;
      lo <= mag;
    end else if (cnt != '0) begin
      hi <= sum[W:1];
      lo <= {sum[0], lo[W-1:1]};
    end
  end

  assign product   = {hi, lo};
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

FILE: hw/rtl/gsbc_divider.sv
// Restoring divider, one quotient bit per cycle, MSB first.
module gsbc_divider #(
  parameter int DVD_W = 40,
  parameter int DVS_W = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DVS_W-1:0]  divisor,
  output logic [DVD_W-1:0]  quotient,
  output gsbc_pkg::unit_stat_t stat
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic [DVS_W:0]   shifted;
  logic             fits;
  logic [DVS_W:0]   trial;

  assign shifted = {rem, quo[DVD_W-1]};
  assign fits    = (shifted >= {1'b0, dvs});
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(DVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend out at the top, quotient bits in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (cnt != '0) begin
      rem <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

FILE: hw/rtl/gyro_still_bias_calibrator.sv
// Channel   Modport  Request carries                          Accepted when
// samples   sink     raw_x, raw_y, raw_z                      valid && ready
// rates     source   rate_x/y/z, window_closed, bias_updated  valid && ready
// cfg       sink     index, data                              valid && ready
//
// An accumulated sample is worked axis by axis on the one-bit-per-cycle squarer between
// accept and emit. A window-closing sample divides the three square sums and, when the window
// is judged still, the three axis sums on the one-bit-per-cycle divider; an empty window
// goes straight from accept to emit. rst is synchronous: it clears the sums, count, biases
// and the output valid and restores the register defaults. A stalled rates request holds
// in its register while the next sample is worked on; only the emit step waits for it
// to be taken.
`include "assert_macros.svh"

module gyro_still_bias_calibrator #(
  parameter int COUNT_BITS = gsbc_pkg::COUNT_BITS_DEFAULT
) (
  input logic           clk,
  input logic           rst,
  gsbc_sample_if.sink   samples,
  gsbc_rate_if.source   rates,
  gsbc_cfg_if.sink      cfg
);

  localparam int SW     = gsbc_pkg::SAMPLE_W;
  localparam int RW     = gsbc_pkg::RATE_W;
  localparam int SUM_W  = SW + COUNT_BITS;
  localparam int SQ_W   = 2 * SW - 2 + COUNT_BITS;
  localparam int CMP_W  = (COUNT_BITS > gsbc_pkg::WLEN_W) ? COUNT_BITS : gsbc_pkg::WLEN_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  gsbc_pkg::state_t state;
  gsbc_pkg::state_t state_next;

  // Configuration
  logic [gsbc_pkg::WLEN_W-1:0] window_length;
  logic [gsbc_pkg::THR_W-1:0]  still_threshold;

  // Calibration state
  logic [COUNT_BITS-1:0]   sample_count;
  logic signed [SW-1:0]    previous_sample [3];
  logic signed [SUM_W-1:0] axis_sum [3];
  logic [SQ_W-1:0]         diff_square_sum [3];
  logic signed [SW-1:0]    axis_bias [3];

  // Per-item working registers
  logic signed [SW-1:0]             sample [3];
  logic [1:0]                       ax;
  logic [gsbc_pkg::TOTAL_W-1:0]     total;
  logic                             closed;
  logic                             updated;
  logic                             sum_neg;

  // Output register
  logic                 out_valid;
  logic signed [RW-1:0] rate_x;
  logic signed [RW-1:0] rate_y;
  logic signed [RW-1:0] rate_z;
  logic                 out_closed;
  logic                 out_updated;

  // Serial units
  logic                         mul_start;
  logic [SW-1:0]                mul_mag;
  logic [gsbc_pkg::PROD_W-1:0]  mul_product;
  gsbc_pkg::unit_stat_t         mul_stat;
  logic                         div_start;
  logic [SQ_W-1:0]              div_dividend;
  logic [SQ_W-1:0]              div_quot;
  gsbc_pkg::unit_stat_t         div_stat;

  logic                 window_open;
  logic signed [SW-1:0] diff;
  logic [SUM_W-1:0]     abs_sum;
  logic                 emit_go;

  // A window stays open below the programmed length and below the count ceiling.
  assign window_open = (CMP_W'(sample_count) < CMP_W'(window_length)) &&
                       (sample_count != COUNT_MAX);

  // Wrapped sample-to-sample difference; its magnitude feeds the squarer.
  assign diff    = sample[ax] - previous_sample[ax];
  assign mul_mag = diff[SW-1] ? SW'(-diff) : SW'(diff);

  assign abs_sum      = axis_sum[ax][SUM_W-1] ? SUM_W'(-axis_sum[ax]) : SUM_W'(axis_sum[ax]);
  assign div_dividend = (state == gsbc_pkg::S_DIVSUM_LOAD) ? SQ_W'(abs_sum)
                                                            : diff_square_sum[ax];

  assign emit_go = !out_valid || rates.ready;

  gsbc_sq_mul u_sq_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mag     (mul_mag),
    .product (mul_product),
    .stat    (mul_stat)
  );

  gsbc_divider #(
    .DVD_W (SQ_W),
    .DVS_W (COUNT_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (sample_count),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsbc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    unique case (state)
      gsbc_pkg::S_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          priority if (window_open) begin
            state_next = gsbc_pkg::S_SQ_LOAD;
          end else if (sample_count == '0) begin
            state_next = gsbc_pkg::S_EMIT;
          end else begin
            state_next = gsbc_pkg::S_DIVSQ_LOAD;
          end
        end
      end
      gsbc_pkg::S_SQ_LOAD: begin
        mul_start  = 1'b1;
        state_next = gsbc_pkg::S_SQ_RUN;
      end
      gsbc_pkg::S_SQ_RUN: begin
        if (mul_stat.done) begin
          state_next = (ax == 2'd2) ? gsbc_pkg::S_EMIT : gsbc_pkg::S_SQ_LOAD;
        end
      end
      gsbc_pkg::S_DIVSQ_LOAD: begin
        div_start  = 1'b1;
        state_next = gsbc_pkg::S_DIVSQ_RUN;
      end
      gsbc_pkg::S_DIVSQ_RUN: begin
        if (div_stat.done) begin
          state_next = (ax == 2'd2) ? gsbc_pkg::S_JUDGE : gsbc_pkg::S_DIVSQ_LOAD;
        end
      end
      gsbc_pkg::S_JUDGE: begin
        state_next = (total < gsbc_pkg::TOTAL_W'(still_threshold)) ? gsbc_pkg::S_DIVSUM_LOAD
                                                                   : gsbc_pkg::S_EMIT;
      end
      gsbc_pkg::S_DIVSUM_LOAD: begin
        div_start  = 1'b1;
        state_next = gsbc_pkg::S_DIVSUM_RUN;
      end
      gsbc_pkg::S_DIVSUM_RUN: begin
        if (div_stat.done) begin
          state_next = (ax == 2'd2) ? gsbc_pkg::S_EMIT : gsbc_pkg::S_DIVSUM_LOAD;
        end
      end
      gsbc_pkg::S_EMIT: begin
        if (emit_go) begin
          state_next = gsbc_pkg::S_IDLE;
        end
      end
      default: state_next = gsbc_pkg::S_IDLE;
    endcase
  end

  assign cfg.ready = 1'b1;

  // Configuration, calibration state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length   <= gsbc_pkg::WLEN_RESET;
      still_threshold <= gsbc_pkg::THR_RESET;
      sample_count    <= '0;
      ax              <= 2'd0;
      out_valid       <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        previous_sample[i] <= '0;
        axis_sum[i]        <= '0;
        diff_square_sum[i] <= '0;
        axis_bias[i]       <= '0;
      end
    end else begin
      if (cfg.valid) begin
        unique case (gsbc_pkg::cfg_reg_t'(cfg.index))
          gsbc_pkg::REG_WINDOW_LENGTH:
            window_length <= cfg.data[gsbc_pkg::WLEN_W-1:0];
          gsbc_pkg::REG_STILL_THRESHOLD:
            still_threshold <= cfg.data[gsbc_pkg::THR_W-1:0];
        endcase
      end

      // Raise valid at emit; drop it once the waiting result is taken.
      if (state == gsbc_pkg::S_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end else if (rates.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        gsbc_pkg::S_IDLE: begin
          if (samples.valid) begin
            ax <= 2'd0;
          end
        end
        gsbc_pkg::S_SQ_LOAD: begin
          axis_sum[ax]        <= axis_sum[ax] + SUM_W'(sample[ax]);
          previous_sample[ax] <= sample[ax];
        end
        gsbc_pkg::S_SQ_RUN: begin
          if (mul_stat.done) begin
            diff_square_sum[ax] <= diff_square_sum[ax] + SQ_W'(mul_product);
            if (ax == 2'd2) begin
              ax           <= 2'd0;
              sample_count <= sample_count + COUNT_BITS'(1);
            end else begin
              ax <= ax + 2'd1;
            end
          end
        end
        gsbc_pkg::S_DIVSQ_RUN, gsbc_pkg::S_DIVSUM_RUN: begin
          if (div_stat.done) begin
            ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
            if (state == gsbc_pkg::S_DIVSUM_RUN) begin
              // Truncate toward zero: divide the magnitude, restore the sign.
              axis_bias[ax] <= sum_neg ? -div_quot[SW-1:0] : div_quot[SW-1:0];
            end
          end
        end
        gsbc_pkg::S_EMIT: begin
          if (emit_go) begin
            if (closed) begin
              sample_count <= '0;
              for (int i = 0; i < 3; i++) begin
                axis_sum[i]        <= '0;
                diff_square_sum[i] <= '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Per-item working registers and output payload.
  always_ff @(posedge clk) begin
    unique case (state)
      gsbc_pkg::S_IDLE: begin
        if (samples.valid) begin
          // Remap to body axes: x' = -y (wrapping), y' = x, z' = z.
          sample[0] <= -samples.raw_y;
          sample[1] <= samples.raw_x;
          sample[2] <= samples.raw_z;
          closed    <= !window_open;
          updated   <= 1'b0;
          total     <= '0;
        end
      end
      gsbc_pkg::S_DIVSQ_RUN: begin
        if (div_stat.done) begin
          total <= total + div_quot[gsbc_pkg::TOTAL_W-1:0];
        end
      end
      gsbc_pkg::S_DIVSUM_LOAD: begin
        sum_neg <= axis_sum[ax][SUM_W-1];
      end
      gsbc_pkg::S_DIVSUM_RUN: begin
        if (div_stat.done) begin
          updated <= 1'b1;
        end
      end
      gsbc_pkg::S_EMIT: begin
        if (emit_go) begin
          rate_x      <= RW'(sample[0]) - RW'(axis_bias[0]);
          rate_y      <= RW'(sample[1]) - RW'(axis_bias[1]);
          rate_z      <= RW'(sample[2]) - RW'(axis_bias[2]);
          out_closed  <= closed;
          out_updated <= updated;
        end
      end
      default: ;
    endcase
  end

  assign rates.valid         = out_valid;
  assign rates.rate_x        = rate_x;
  assign rates.rate_y        = rate_y;
  assign rates.rate_z        = rate_z;
  assign rates.window_closed = out_closed;
  assign rates.bias_updated  = out_updated;

  `ASSERT_CLK(a_bias_hold, (state != gsbc_pkg::S_DIVSUM_RUN) |=> ($stable(axis_bias[0]) && $stable(axis_bias[1]) && $stable(axis_bias[2])), "bias changed outside a mean division")
  `ASSERT_CLK(a_valid_from_emit, $rose(rates.valid) |-> $past(state == gsbc_pkg::S_EMIT), "result raised outside emit")
  `ASSERT_CLK(a_mul_free, (state == gsbc_pkg::S_SQ_LOAD) |-> !mul_stat.busy, "squarer started while busy")
  `ASSERT_CLK(a_div_free, (state == gsbc_pkg::S_DIVSQ_LOAD || state == gsbc_pkg::S_DIVSUM_LOAD) |-> !div_stat.busy, "divider started while busy")
  `ASSERT_ALWAYS(a_axis_rewound, (!rst && state == gsbc_pkg::S_EMIT) |-> (ax == 2'd0), "axis index not rewound at emit")

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Count saturation point of the block at its default width: a full count also closes a window
  localparam int unsigned COUNT_LIMIT = (1 << gsbc_pkg::COUNT_BITS_DEFAULT) - 1;
  localparam int unsigned WLEN_MAX = (1 << gsbc_pkg::WLEN_W) - 1;
  localparam int unsigned THR_MAX = (1 << gsbc_pkg::THR_W) - 1;
  localparam int unsigned RANDOM_ITEMS = 150;
  // Tail wait, with margin over the longest window-closing sample at the default width
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  typedef struct {
    logic signed [gsbc_pkg::RATE_W-1:0] x;
    logic signed [gsbc_pkg::RATE_W-1:0] y;
    logic signed [gsbc_pkg::RATE_W-1:0] z;
    logic                               closed;
    logic                               updated;
  } rate_t;

  logic clk;
  logic rst;

  gsbc_sample_if smp();
  gsbc_rate_if   rt();
  gsbc_cfg_if    cfg_ch();

  gyro_still_bias_calibrator DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (smp),
    .rates   (rt),
    .cfg     (cfg_ch)
  );

  // Register copies, kept in step with every accepted write
  logic [gsbc_pkg::WLEN_W-1:0] win_len = gsbc_pkg::WLEN_RESET;
  logic [gsbc_pkg::THR_W-1:0]  still_thr = gsbc_pkg::THR_RESET;

  // Calibration state mirrored from the block, all clear after reset
  int unsigned                          held = 0;
  logic signed [gsbc_pkg::SAMPLE_W-1:0] last_body [3] = '{default: '0};
  longint                               axis_total [3] = '{default: 0};
  longint unsigned                      spread_sum [3] = '{default: 0};
  logic signed [gsbc_pkg::SAMPLE_W-1:0] bias [3] = '{default: '0};

  // Rates still owed by the block, oldest first
  rate_t expected_rates [$];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned rates_checked = 0;
  int unsigned windows_closed = 0;
  int unsigned bias_updates = 0;

  // calm switches off all random idling on both channels; hold_left stalls the rates sink
  bit          calm = 1'b0;
  int unsigned hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance the mirrored state by one accepted sample and queue the rates it must produce
  function automatic void predict_body_rates(logic signed [gsbc_pkg::SAMPLE_W-1:0] rx,
                                             logic signed [gsbc_pkg::SAMPLE_W-1:0] ry,
                                             logic signed [gsbc_pkg::SAMPLE_W-1:0] rz);
    logic signed [gsbc_pkg::SAMPLE_W-1:0] body [3];
    logic signed [gsbc_pkg::SAMPLE_W-1:0] step;
    longint unsigned                      spread_total;
    rate_t                                want;
    int                                   a;
    // Body frame: x is the negated sensor y, wrapped to 16 bits
    body[0] = -ry;
    body[1] = rx;
    body[2] = rz;
    want.closed = 1'b0;
    want.updated = 1'b0;
    if (held < win_len && held < COUNT_LIMIT) begin
      for (a = 0; a < 3; a++) begin
        step = body[a] - last_body[a];
        axis_total[a] += body[a];
        spread_sum[a] += longint'(step) * longint'(step);
        last_body[a] = body[a];
      end
      held++;
    end else begin
      // This sample closes the window and is not accumulated
      want.closed = 1'b1;
      windows_closed++;
      if (held != 0) begin
        spread_total = 0;
        for (a = 0; a < 3; a++) spread_total += spread_sum[a] / held;
        if (spread_total < still_thr) begin
          for (a = 0; a < 3; a++)
            bias[a] = gsbc_pkg::SAMPLE_W'(axis_total[a] / longint'(held));
          want.updated = 1'b1;
          bias_updates++;
        end
      end
      for (a = 0; a < 3; a++) begin
        axis_total[a] = 0;
        spread_sum[a] = 0;
      end
      held = 0;
    end
    want.x = body[0] - bias[0];
    want.y = body[1] - bias[1];
    want.z = body[2] - bias[2];
    expected_rates.push_back(want);
  endfunction

  // Offer one sample request and hold it until taken; valid stays high for a back-to-back sample.
  // Ready is sampled mid-cycle, where it holds the value seen at the next rising edge.
  task automatic send_sample(logic signed [gsbc_pkg::SAMPLE_W-1:0] rx,
                             logic signed [gsbc_pkg::SAMPLE_W-1:0] ry,
                             logic signed [gsbc_pkg::SAMPLE_W-1:0] rz);
    bit took;
    while (!calm && $urandom_range(99) < 10) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.raw_x <= rx;
    smp.raw_y <= ry;
    smp.raw_z <= rz;
    do begin
      @(negedge clk);
      took = smp.ready;
      @(posedge clk);
    end while (!took);
    predict_body_rates(rx, ry, rz);
    items_sent++;
  endtask

  function automatic logic signed [gsbc_pkg::SAMPLE_W-1:0] jittered(
      logic signed [gsbc_pkg::SAMPLE_W-1:0] base,
      int unsigned spread);
    return gsbc_pkg::SAMPLE_W'(int'(base) + int'($urandom_range(2 * spread)) - int'(spread));
  endfunction

  // A run of samples scattered closely about one rate: what a gyro at rest delivers
  task automatic send_still_run(logic signed [gsbc_pkg::SAMPLE_W-1:0] bx,
                                logic signed [gsbc_pkg::SAMPLE_W-1:0] by,
                                logic signed [gsbc_pkg::SAMPLE_W-1:0] bz,
                                int unsigned n, int unsigned spread);
    repeat (n) send_sample(jittered(bx, spread), jittered(by, spread), jittered(bz, spread));
  endtask

  // Drop the sample request, then wait for every owed rate so the block is idle
  task automatic settle();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(gsbc_pkg::cfg_reg_t idx, int unsigned value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= gsbc_pkg::CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      gsbc_pkg::REG_WINDOW_LENGTH:   win_len = gsbc_pkg::WLEN_W'(value);
      gsbc_pkg::REG_STILL_THRESHOLD: still_thr = gsbc_pkg::THR_W'(value);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Compare one taken rates request against the oldest owed one
  task automatic check_rates();
    rate_t want;
    if (expected_rates.size() == 0) begin
      $display("%0t: rates request with none owed: x=%0d y=%0d z=%0d closed=%0b updated=%0b",
               $time, rt.rate_x, rt.rate_y, rt.rate_z, rt.window_closed, rt.bias_updated);
      mismatches++;
      return;
    end
    want = expected_rates.pop_front();
    rates_checked++;
    if (rt.rate_x !== want.x || rt.rate_y !== want.y || rt.rate_z !== want.z ||
        rt.window_closed !== want.closed || rt.bias_updated !== want.updated) begin
      $display("%0t: rates mismatch, expected x=%0d y=%0d z=%0d closed=%0b updated=%0b",
               $time, want.x, want.y, want.z, want.closed, want.updated);
      $display("%0t:                 actual   x=%0d y=%0d z=%0d closed=%0b updated=%0b",
               $time, rt.rate_x, rt.rate_y, rt.rate_z, rt.window_closed, rt.bias_updated);
      mismatches++;
    end
  endtask

  // Rates sink: take requests, stall at random, and honour a requested hold-off.
  // The handshake is judged mid-cycle, where it holds what the next rising edge sees.
  initial begin
    rt.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (!rst && rt.valid && rt.ready) check_rates();
      @(posedge clk);
      if (hold_left > 0) begin
        rt.ready <= 1'b0;
        hold_left--;
      end else begin
        rt.ready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  // Field extremes under the reset register values; the first difference is taken against zero
  task automatic test_field_extremes();
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
    send_sample(-16'sd1, -16'sd1, -16'sd1);
    send_sample(16'sd32767, -16'sd32768, 16'sd0);
    send_sample(-16'sd32768, 16'sd32767, -16'sd1);
  endtask

  // Zero length: the partial window closes at once, then every sample closes an empty window
  task automatic test_empty_window();
    settle();
    write_reg(gsbc_pkg::REG_WINDOW_LENGTH, 0);
    send_sample(16'sd5, -16'sd5, 16'sd9);
    send_sample(16'sd0, 16'sd1, -16'sd1);
    send_sample(-16'sd32768, 16'sd32767, 16'sd32767);
  endtask

  // Maximum threshold: a window of four near-constant samples, then one-sample windows
  task automatic test_still_windows();
    settle();
    write_reg(gsbc_pkg::REG_STILL_THRESHOLD, THR_MAX);
    write_reg(gsbc_pkg::REG_WINDOW_LENGTH, 4);
    send_sample(-16'sd3, 16'sd5, 16'sd100);
    send_sample(-16'sd2, 16'sd5, 16'sd100);
    send_sample(-16'sd2, 16'sd5, 16'sd101);
    send_sample(-16'sd2, 16'sd6, 16'sd100);
    send_sample(16'sd7, 16'sd7, 16'sd7);
    settle();
    // One-sample windows fed with samples at the field extremes
    write_reg(gsbc_pkg::REG_WINDOW_LENGTH, 1);
    send_sample(16'sd32767, -16'sd32768, -16'sd32768);
    send_sample(16'sd32767, -16'sd32768, -16'sd32768);
    send_sample(-16'sd32768, -16'sd32767, 16'sd32767);
  endtask

  // Zero threshold: no window can be judged still, even with constant samples
  task automatic test_threshold_zero();
    settle();
    write_reg(gsbc_pkg::REG_STILL_THRESHOLD, 0);
    write_reg(gsbc_pkg::REG_WINDOW_LENGTH, 2);
    send_sample(16'sd40, 16'sd40, 16'sd40);
    send_sample(16'sd40, 16'sd40, 16'sd40);
    send_sample(16'sd40, 16'sd40, 16'sd40);
  endtask

  // Shrink the window part-way through: it closes at once and divides by the samples held
  task automatic test_window_shrink();
    settle();
    write_reg(gsbc_pkg::REG_STILL_THRESHOLD, THR_MAX);
    write_reg(gsbc_pkg::REG_WINDOW_LENGTH, 8);
    send_still_run(-16'sd1200, 16'sd333, 16'sd17, 3, 2);
    settle();
    write_reg(gsbc_pkg::REG_WINDOW_LENGTH, 3);
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd1, 16'sd2, 16'sd3);
  endtask

  // Hold the rates sink off while samples keep coming, so the block fills and stalls its input;
  // then pause the sender until every owed rate has arrived and send a second run
  task automatic test_backpressure();
    settle();
    write_reg(gsbc_pkg::REG_WINDOW_LENGTH, 5);
    write_reg(gsbc_pkg::REG_STILL_THRESHOLD, 64);
    hold_left = HOLD_OFF_CYCLES;
    send_still_run(16'sd2000, -16'sd2000, 16'sd0, 12, 2);
    settle();
    send_still_run(-16'sd500, 16'sd500, 16'sd250, 8, 1);
  endtask

  // Longest window with no idling on either side; it also reaches the count limit
  task automatic test_full_window();
    settle();
    calm = 1'b1;
    write_reg(gsbc_pkg::REG_WINDOW_LENGTH, WLEN_MAX);
    write_reg(gsbc_pkg::REG_STILL_THRESHOLD, THR_MAX);
    send_still_run(-16'sd7000, 16'sd12345, -16'sd321, WLEN_MAX + 2, 2);
    settle();
    calm = 1'b0;
  endtask

  // Random phases: mostly still runs spanning a window, with some raw noise in between
  task automatic test_random_traffic();
    int unsigned sent_before;
    int unsigned spread;
    sent_before = items_sent;
    while (items_sent - sent_before < RANDOM_ITEMS) begin
      settle();
      calm = ($urandom_range(9) == 0);
      case ($urandom_range(9))
        0:       write_reg(gsbc_pkg::REG_WINDOW_LENGTH, 0);
        1, 2:    write_reg(gsbc_pkg::REG_WINDOW_LENGTH, $urandom_range(100, 9));
        default: write_reg(gsbc_pkg::REG_WINDOW_LENGTH, $urandom_range(8, 1));
      endcase
      case ($urandom_range(3))
        0:       write_reg(gsbc_pkg::REG_STILL_THRESHOLD, 0);
        1:       write_reg(gsbc_pkg::REG_STILL_THRESHOLD, $urandom_range(64));
        2:       write_reg(gsbc_pkg::REG_STILL_THRESHOLD, $urandom_range(THR_MAX));
        default: write_reg(gsbc_pkg::REG_STILL_THRESHOLD, THR_MAX);
      endcase
      repeat ($urandom_range(6, 3)) begin
        if (items_sent - sent_before >= RANDOM_ITEMS) break;
        if ($urandom_range(4) != 0) begin
          spread = ($urandom_range(3) == 0) ? $urandom_range(200) : $urandom_range(3);
          send_still_run(gsbc_pkg::SAMPLE_W'($urandom), gsbc_pkg::SAMPLE_W'($urandom),
                         gsbc_pkg::SAMPLE_W'($urandom), win_len + 1 + $urandom_range(2),
                         spread);
        end else begin
          repeat ($urandom_range(4, 1))
            send_sample(gsbc_pkg::SAMPLE_W'($urandom), gsbc_pkg::SAMPLE_W'($urandom),
                        gsbc_pkg::SAMPLE_W'($urandom));
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    smp.valid <= 1'b0;
    smp.raw_x <= '0;
    smp.raw_y <= '0;
    smp.raw_z <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= gsbc_pkg::REG_WINDOW_LENGTH;
    cfg_ch.data <= '0;
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_empty_window();
    test_still_windows();
    test_threshold_zero();
    test_window_shrink();
    test_backpressure();
    test_full_window();
    test_random_traffic();

    // Drain, then allow one more closing sample's worth of cycles for any stray request
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d samples and checked %0d rates requests.", items_sent, rates_checked);
    $display("Windows closed: %0d, bias updates: %0d, mismatches: %0d.",
             windows_closed, bias_updates, mismatches);
    if (mismatches == 0) begin
      $display("gyro_still_bias_calibrator test passed");
    end else begin
      $display("gyro_still_bias_calibrator test failed");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("%0t: timed out with %0d rates owed", $time, expected_rates.size());
    $display("gyro_still_bias_calibrator test failed");
    $finish;
  end

endmodule

FILE: gyro_still_bias_calibrator.f
+incdir+hw/rtl
hw/rtl/gsbc_pkg.sv
hw/rtl/gsbc_ifs.sv
hw/rtl/gsbc_sq_mul.sv
hw/rtl/gsbc_divider.sv
hw/rtl/gyro_still_bias_calibrator.sv
tb/tb.sv
